// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TEBM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TEBM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tebm_pkg.sv =====
package tebm_pkg;

    localparam int TILE_W     = 4;
    localparam int TILE_COUNT = 10;
    localparam logic [TILE_W-1:0] LAST_TILE = TILE_W'(TILE_COUNT - 1);

    // one side scores at most 1000, four sides at most 4000
    localparam int SIDE_W  = 10;
    localparam int SCORE_W = 12;

    localparam logic [SIDE_W-1:0] FULL_EXACT    = 10'd1000;
    localparam logic [SIDE_W-1:0] FULL_PER_BIT  = 10'd6;
    localparam logic [SIDE_W-1:0] SOLID_EXACT   = 10'd500;
    localparam logic [SIDE_W-1:0] SOLID_PER_BIT = 10'd3;
    localparam logic [SIDE_W-1:0] OTHER_EXACT   = 10'd100;
    localparam logic [SIDE_W-1:0] OTHER_PER_BIT = 10'd1;

    localparam logic [3:0] NIBBLE_ONES  = 4'b1111;
    localparam logic [3:0] NIBBLE_ZEROS = 4'b0000;

    typedef logic [3:0] edge_t;
    // index 0 north, 1 east, 2 south, 3 west
    typedef edge_t [3:0] orient_t;
    typedef logic [3:0][7:0] code_set_t;

    function automatic orient_t tile_shape(input logic [TILE_W-1:0] idx);
        orient_t s;
        unique case (idx)
            4'd0:    s = {4'hF, 4'h3, 4'h0, 4'hC};
            4'd1:    s = {4'h3, 4'h0, 4'h0, 4'hC};
            4'd2:    s = {4'hF, 4'h3, 4'hC, 4'hF};
            4'd3:    s = {4'h7, 4'h0, 4'h0, 4'hE};
            4'd4:    s = {4'h7, 4'h0, 4'hC, 4'hF};
            4'd5:    s = {4'h3, 4'h0, 4'hE, 4'hF};
            4'd6:    s = {4'h3, 4'h0, 4'h8, 4'hF};
            4'd7:    s = {4'h1, 4'h0, 4'hC, 4'hF};
            4'd8:    s = {4'h1, 4'h0, 4'h0, 4'h8};
            4'd9:    s = {4'hF, 4'h7, 4'hE, 4'hF};
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

// ===== src/tebm_score.sv =====
module tebm_score (
    input  tebm_pkg::orient_t            orient,
    input  tebm_pkg::code_set_t          codes,
    output logic [tebm_pkg::SCORE_W-1:0] total
);
    import tebm_pkg::*;

    function automatic logic [SIDE_W-1:0] side_score(input edge_t mine, input logic [7:0] nb);
        edge_t             agree;
        logic [2:0]        cnt;
        logic [SIDE_W-1:0] res;
        agree = ~(mine ^ nb[3:0]);
        cnt   = 3'(agree[0]) + 3'(agree[1]) + 3'(agree[2]) + 3'(agree[3]);
        if (nb[7:4] == NIBBLE_ONES) begin
            res = (agree == NIBBLE_ONES) ? FULL_EXACT : SIDE_W'(cnt) * FULL_PER_BIT;
        end else if (nb[3:0] == NIBBLE_ONES || nb[3:0] == NIBBLE_ZEROS) begin
            res = (agree == NIBBLE_ONES) ? SOLID_EXACT : SIDE_W'(cnt) * SOLID_PER_BIT;
        end else begin
            res = (agree == NIBBLE_ONES) ? OTHER_EXACT : SIDE_W'(cnt) * OTHER_PER_BIT;
        end
        return res;
    endfunction

    always_comb begin
        total = '0;
        for (int k = 0; k < 4; k++) begin
            total = total + SCORE_W'(side_score(orient[k], codes[k]));
        end
    end

endmodule

// ===== src/tile_edge_best_match_core.sv =====
// tile_edge_best_match_core
//
// Picks the tile shape and orientation that best fits four neighbor edge
// codes. The input channel (s_valid/s_ready) carries one item of four 8-bit
// codes; the result channel (m_valid/m_ready) returns tile index, rotation
// and flip flag, one result item per input item.
//
// Sequencing: the sequencer scores one of 80 orientations per cycle through a
// single score unit (10 tiles x 2 flips x 4 turns), then loads the output
// register with the corner fixup applied once the output is free.
// s_ready is high only while idle, so no new item is taken while a search runs.
//
// The result sits in an output register. A new item may be accepted while
// a result still waits; if the receiver is still stalled when the next
// search ends, the block holds in its final state until the output frees.
//
// Reset (aresetn, synchronous, active low) returns to idle and drops m_valid.
`include "assert_macros.svh"

module tile_edge_best_match_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_north_code,
    input  logic [7:0] s_east_code,
    input  logic [7:0] s_south_code,
    input  logic [7:0] s_west_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [tebm_pkg::TILE_W-1:0] m_tile_index,
    output logic [1:0] m_rotation,
    output logic       m_flip_flag
);
    import tebm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg, state_next;

    // search position
    logic [TILE_W-1:0] tile_reg, tile_next;
    logic              pass_reg, pass_next;
    logic [1:0]        turn_reg, turn_next;
    orient_t           cur_reg, cur_next;
    code_set_t         codes_reg, codes_next;

    // running best
    logic [SCORE_W-1:0] best_reg, best_next;
    logic [TILE_W-1:0]  best_tile_reg, best_tile_next;
    logic [1:0]         best_rot_reg, best_rot_next;
    logic               best_flag_reg, best_flag_next;
    logic               first_reg, first_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [TILE_W-1:0] out_tile_reg, out_tile_next;
    logic [1:0]        out_rot_reg, out_rot_next;
    logic              out_flag_reg, out_flag_next;

    logic [SCORE_W-1:0] total;
    logic               take;
    logic               out_free;
    logic               corner;
    orient_t            rot_cur;

    function automatic edge_t mirror4(input edge_t v);
        return {v[0], v[1], v[2], v[3]};
    endfunction

    tebm_score u_score (
        .orient (cur_reg),
        .codes  (codes_reg),
        .total  (total)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign take     = first_reg || (total > best_reg);

    // quarter turn: west to north, north to east, east to south, south to west
    assign rot_cur = {cur_reg[2], cur_reg[1], cur_reg[0], cur_reg[3]};

    // flagged corner tiles get one extra quarter turn
    assign corner = best_flag_reg &&
                    (best_tile_reg == 4'd1 || best_tile_reg == 4'd3 || best_tile_reg == 4'd9);

    always_comb begin
        state_next     = state_reg;
        tile_next      = tile_reg;
        pass_next      = pass_reg;
        turn_next      = turn_reg;
        cur_next       = cur_reg;
        codes_next     = codes_reg;
        best_next      = best_reg;
        best_tile_next = best_tile_reg;
        best_rot_next  = best_rot_reg;
        best_flag_next = best_flag_reg;
        first_next     = first_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        out_tile_next  = out_tile_reg;
        out_rot_next   = out_rot_reg;
        out_flag_next  = out_flag_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    codes_next = {s_west_code, s_south_code, s_east_code, s_north_code};
                    tile_next  = '0;
                    pass_next  = 1'b0;
                    turn_next  = '0;
                    cur_next   = tile_shape('0);
                    first_next = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (take) begin
                    best_next      = total;
                    best_tile_next = tile_reg;
                    best_rot_next  = turn_reg;
                    best_flag_next = pass_reg ^ tile_reg[0];
                end
                first_next = 1'b0;
                turn_next  = turn_reg + 2'd1;
                if (turn_reg != 2'd3) begin
                    cur_next = rot_cur;
                end else if (!pass_reg) begin
                    // four turns bring the shape home; now X flip it
                    pass_next   = 1'b1;
                    cur_next[0] = mirror4(rot_cur[2]);
                    cur_next[2] = mirror4(rot_cur[0]);
                    cur_next[1] = mirror4(rot_cur[1]);
                    cur_next[3] = mirror4(rot_cur[3]);
                end else if (tile_reg == LAST_TILE) begin
                    state_next = ST_DONE;
                end else begin
                    pass_next = 1'b0;
                    tile_next = tile_reg + TILE_W'(1);
                    cur_next  = tile_shape(tile_reg + TILE_W'(1));
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_tile_next = best_tile_reg;
                    out_rot_next  = best_rot_reg + 2'(corner);
                    out_flag_next = best_flag_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            first_reg   <= 1'b1;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            first_reg   <= first_next;
        end
    end

    always_ff @(posedge aclk) begin
        tile_reg      <= tile_next;
        pass_reg      <= pass_next;
        turn_reg      <= turn_next;
        cur_reg       <= cur_next;
        codes_reg     <= codes_next;
        best_reg      <= best_next;
        best_tile_reg <= best_tile_next;
        best_rot_reg  <= best_rot_next;
        best_flag_reg <= best_flag_next;
        out_tile_reg  <= out_tile_next;
        out_rot_reg   <= out_rot_next;
        out_flag_reg  <= out_flag_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_tile_index = out_tile_reg;
    assign m_rotation   = out_rot_reg;
    assign m_flip_flag  = out_flag_reg;

    // search never walks past the last tile
    `TEBM_ASSERT_IMP(a_tile_range, aclk, aresetn, state_reg == ST_RUN, tile_reg <= LAST_TILE, "tile counter out of range")
    // an accepted item starts the search at the first orientation
    `TEBM_ASSERT_NXT(a_start, aclk, aresetn, s_valid && s_ready, state_reg == ST_RUN && tile_reg == '0 && first_reg, "search did not start cleanly")
    // a finished search with a free output always presents a result
    `TEBM_ASSERT_NXT(a_deliver, aclk, aresetn, state_reg == ST_DONE && out_free, m_valid && state_reg == ST_IDLE, "finished search not delivered")
    // a shown result names a real tile
    `TEBM_ASSERT_IMP(a_out_tile, aclk, aresetn, m_valid, m_tile_index <= LAST_TILE, "result tile out of range")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

// Block-level check of tile_edge_best_match_core.
// Every accepted item goes through a local scoring search over all 80 tile
// orientations; the winner is queued and compared field by field with the
// next result item taken off the m_ channel.
module testbench;
    import tebm_pkg::*;

    localparam int PERIOD_NS = 12;

    // Tile edges in north, east, south, west order; entry 0 is leftmost.
    localparam logic [0:9][0:3][3:0] SHAPES = {
        16'hC03F, 16'hC003, 16'hFC3F, 16'hE007, 16'hFC07,
        16'hFE03, 16'hF803, 16'hFC01, 16'h8001, 16'hFE7F
    };
    // Tiles 1, 3 and 9 take an extra quarter turn when the recorded flag is set.
    localparam logic [0:9] CORNER_TILES = 10'b0101000001;

    localparam logic [3:0] FULL_GROUP = 4'hF;
    localparam int FULL_EXACT = 1000, FULL_BIT = 6;
    localparam int SOLID_EXACT = 500, SOLID_BIT = 3;
    localparam int OTHER_EXACT = 100, OTHER_BIT = 1;

    localparam int LOG_LIMIT = 40;

    typedef logic [0:3][3:0] edge_set_t;
    typedef logic [0:3][7:0] code_set_t;

    typedef struct packed {
        logic [TILE_W-1:0] tile;
        logic [1:0]        rot;
        logic              flip;
    } placement_t;

    // receiver behavior, switched in segments of random length
    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_HOLD,
        STALL_SPARSE
    } stall_kind_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_north_code = 8'h00;
    logic [7:0] s_east_code = 8'h00;
    logic [7:0] s_south_code = 8'h00;
    logic [7:0] s_west_code = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [TILE_W-1:0] m_tile_index;
    logic [1:0] m_rotation;
    logic       m_flip_flag;

    placement_t  expected_placements[$];
    int          mismatch_count = 0;
    int          burst_left = 0;
    int          stall_left = 0;
    stall_kind_t stall_kind = STALL_NONE;

    tile_edge_best_match_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_north_code (s_north_code),
        .s_east_code  (s_east_code),
        .s_south_code (s_south_code),
        .s_west_code  (s_west_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_tile_index (m_tile_index),
        .m_rotation   (m_rotation),
        .m_flip_flag  (m_flip_flag)
    );

    always #(PERIOD_NS / 2) aclk = ~aclk;

    function automatic logic [3:0] reverse_bits(input logic [3:0] v);
        return {v[0], v[1], v[2], v[3]};
    endfunction

    // Edges of one tile after an optional X flip and then some quarter turns.
    // X flip: swap north/south, mirror every edge.
    // Quarter turn: west->north, north->east, east->south, south->west.
    function automatic edge_set_t oriented_edges(input int tile, input bit flipped,
                                                 input int turns);
        edge_set_t  e;
        logic [3:0] tmp;
        int         i;
        e = SHAPES[tile];
        if (flipped) begin
            tmp  = e[0];
            e[0] = reverse_bits(e[2]);
            e[2] = reverse_bits(tmp);
            e[1] = reverse_bits(e[1]);
            e[3] = reverse_bits(e[3]);
        end
        for (i = 0; i < turns; i++) begin
            tmp  = e[0];
            e[0] = e[3];
            e[3] = e[2];
            e[2] = e[1];
            e[1] = tmp;
        end
        return e;
    endfunction

    // One side against one neighbor: class picks the exact bonus and the
    // per-bit weight; only the low nibble is compared.
    function automatic int edge_score(input logic [3:0] mine, input logic [7:0] code);
        logic [3:0] agree;
        int         exact_pts;
        int         bit_pts;
        int         hits;
        int         i;
        if (code[7:4] == FULL_GROUP) begin
            exact_pts = FULL_EXACT;
            bit_pts   = FULL_BIT;
        end else if (code[3:0] == NIBBLE_ONES || code[3:0] == NIBBLE_ZEROS) begin
            exact_pts = SOLID_EXACT;
            bit_pts   = SOLID_BIT;
        end else begin
            exact_pts = OTHER_EXACT;
            bit_pts   = OTHER_BIT;
        end
        agree = ~(mine ^ code[3:0]);
        if (agree == 4'hF)
            return exact_pts;
        hits = 0;
        for (i = 0; i < 4; i++)
            hits += agree[i];
        return hits * bit_pts;
    endfunction

    // Full search in tile, flip, turn order; first strictly higher total wins.
    function automatic placement_t best_placement(input code_set_t codes);
        placement_t p;
        edge_set_t  cur;
        int         best;
        int         total;
        int         t;
        int         f;
        int         r;
        int         k;
        best = -1;
        p    = '0;
        for (t = 0; t < 10; t++) begin
            for (f = 0; f < 2; f++) begin
                for (r = 0; r < 4; r++) begin
                    cur   = oriented_edges(t, f[0], r);
                    total = 0;
                    for (k = 0; k < 4; k++)
                        total += edge_score(cur[k], codes[k]);
                    if (total > best) begin
                        best   = total;
                        p.tile = TILE_W'(t);
                        p.rot  = 2'(r);
                        // recorded flag keeps odd-tile parity
                        p.flip = f[0] ^ t[0];
                    end
                end
            end
        end
        if (p.flip && CORNER_TILES[p.tile])
            p.rot = p.rot + 2'd1;
        return p;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= LOG_LIMIT)
            $display("%0t ns mismatch: %s", $realtime, what);
    endtask

    // Sender: bursts of back-to-back items, then a gap of random length.
    // Valid stays high across a burst and drops only when the burst ends.
    task automatic offer_codes(input code_set_t codes);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120)
                                              : $urandom_range(1, 6);
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 10);
        end
        s_valid      <= 1'b1;
        s_north_code <= codes[0];
        s_east_code  <= codes[1];
        s_south_code <= codes[2];
        s_west_code  <= codes[3];
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expected_placements.push_back(best_placement(codes));
        burst_left--;
        if (burst_left == 0)
            s_valid <= 1'b0;
    endtask

    // Class corners: all zeros, all ones, full group with solid nibbles,
    // mixed classes per side.
    task automatic test_class_extremes();
        offer_codes({8'h00, 8'h00, 8'h00, 8'h00});
        offer_codes({8'hFF, 8'hFF, 8'hFF, 8'hFF});
        offer_codes({8'hF0, 8'hF0, 8'hF0, 8'hF0});
        offer_codes({8'h0F, 8'h0F, 8'h0F, 8'h0F});
        offer_codes({8'hF5, 8'h0A, 8'h36, 8'h00});
        offer_codes({8'hA5, 8'h5A, 8'hC3, 8'h3C});
    endtask

    // Exact fits: each tile as stored behind full neighbors, then the
    // corner tiles flipped and turned.
    task automatic test_tile_orientations();
        edge_set_t e;
        int        t;
        int        k;
        code_set_t c;
        for (t = 0; t < 10; t++) begin
            e = oriented_edges(t, 1'b0, 0);
            for (k = 0; k < 4; k++)
                c[k] = {FULL_GROUP, e[k]};
            offer_codes(c);
        end
        for (t = 1; t < 10; t++) begin
            if (CORNER_TILES[t]) begin
                e = oriented_edges(t, 1'b1, 3);
                for (k = 0; k < 4; k++)
                    c[k] = {(k % 2 == 0) ? FULL_GROUP : 4'h3, e[k]};
                offer_codes(c);
            end
        end
    endtask

    // Mostly tile-shaped neighbors (random orientation, class, an odd bit
    // error) so exact hits and near ties are common; the rest is noise.
    task automatic test_random_codes(input int count);
        edge_set_t e;
        code_set_t c;
        int        i;
        int        k;
        int        b;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 6) begin
                e = oriented_edges($urandom_range(0, 9), $urandom_range(0, 1),
                                   $urandom_range(0, 3));
                for (k = 0; k < 4; k++) begin
                    case ($urandom_range(0, 2))
                        0:       c[k] = {FULL_GROUP, e[k]};
                        1:       c[k] = {4'($urandom), e[k]};
                        default: c[k] = {4'h0, e[k]};
                    endcase
                    if ($urandom_range(0, 3) == 0) begin
                        b       = $urandom_range(0, 3);
                        c[k][b] = ~c[k][b];
                    end
                end
            end else begin
                c = $urandom;
            end
            offer_codes(c);
        end
    endtask

    // Receiver: segments of always-ready, coin-flip, hard stall and sparse
    // ready, so stalls land on every phase of the search.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_kind = stall_kind_t'($urandom_range(0, 3));
            stall_left = $urandom_range(10, 250);
        end
        stall_left--;
        case (stall_kind)
            STALL_NONE:   m_ready <= 1'b1;
            STALL_COIN:   m_ready <= 1'($urandom_range(0, 1));
            STALL_HOLD:   m_ready <= 1'b0;
            STALL_SPARSE: m_ready <= ($urandom_range(0, 15) == 0);
            default:      m_ready <= 1'b1;
        endcase
    end

    // Result check against the oldest expectation.
    always @(posedge aclk) begin : check_results
        placement_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_placements.size() == 0) begin
                report_mismatch($sformatf("unexpected result tile %0d rot %0d flip %0d",
                                          m_tile_index, m_rotation, m_flip_flag));
            end else begin
                want = expected_placements.pop_front();
                if (m_tile_index !== want.tile)
                    report_mismatch($sformatf("tile_index %0d, want %0d",
                                              m_tile_index, want.tile));
                if (m_rotation !== want.rot)
                    report_mismatch($sformatf("rotation %0d, want %0d",
                                              m_rotation, want.rot));
                if (m_flip_flag !== want.flip)
                    report_mismatch($sformatf("flip_flag %0d, want %0d",
                                              m_flip_flag, want.flip));
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_class_extremes();
        test_tile_orientations();
        test_random_codes(530);

        if (burst_left != 0)
            s_valid <= 1'b0;
        burst_left = 0;

        // drain, then watch for stray results past the search latency
        while (expected_placements.size() != 0)
            @(posedge aclk);
        repeat (120) @(posedge aclk);

        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Hang guard: well past the slowest legal run.
    initial begin
        #15_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
